/* sv/sxf_pkg.sv */
// Package for the SysEx command framer: word types, burst record, framing constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package sxf_pkg;

  localparam int BURST_MAX = 8;
  localparam int BURST_IDX_W = $clog2(BURST_MAX);
  localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

  localparam int MFR_ID_W = 21;
  localparam int MODEL_ID_W = 7;
  localparam int CFG_DATA_W = MFR_ID_W;

  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_END = 8'hF7;
  localparam logic [7:0] CHECKSUM_MASK = 8'h7F;

  localparam logic [BURST_CNT_W-1:0] HEADER_LEN = BURST_CNT_W'(6);
  localparam logic [BURST_CNT_W-1:0] TRAILER_LEN = BURST_CNT_W'(2);

  typedef enum logic {
    CFG_MANUFACTURER_ID = 1'b0,
    CFG_MODEL_ID        = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_first;
    logic       is_last;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_message;
  } msg_word_t;

  typedef struct packed {
    logic                  we;
    cfg_index_t            index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // Words produced by one command byte, sent from slot 0 upward.
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BURST_CNT_W-1:0]    count;
    logic                      term;
  } burst_t;

endpackage
`default_nettype wire

/* sv/sxf_framer.sv */
// Framing state (running XOR, open-message flag) and configuration registers.
// Turns one command word into a burst of message bytes. Uses sxf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sxf_framer
  import sxf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_write_t cfg,
  input  wire cmd_word_t  cmd,
  input  wire logic       take,
  output burst_t          burst
);

  logic [MFR_ID_W-1:0]   manufacturer_id;
  logic [MODEL_ID_W-1:0] model_id;
  logic [7:0]            running_xor;
  logic [7:0]            running_xor_next;
  logic                  in_message;
  logic                  in_message_next;

  logic [7:0] m0, m1, m2, md;
  logic [7:0] hdr_xor;
  logic [7:0] body_xor;

  always_comb begin
    m0 = {3'b000, manufacturer_id[20:16]};
    m1 = {1'b0, manufacturer_id[14:8]};
    m2 = {1'b0, manufacturer_id[6:0]};
    md = {1'b0, model_id};
    hdr_xor = SYX_START ^ m0 ^ m1 ^ m2 ^ md ^ cmd.data_byte;
    body_xor = running_xor ^ cmd.data_byte;

    burst = '0;
    running_xor_next = running_xor;
    in_message_next = in_message;

    if (cmd.is_first) begin
      burst.bytes[0] = SYX_START;
      burst.bytes[1] = m0;
      burst.bytes[2] = m1;
      burst.bytes[3] = m2;
      burst.bytes[4] = md;
      burst.bytes[5] = cmd.data_byte;
      burst.bytes[6] = hdr_xor & CHECKSUM_MASK;
      burst.bytes[7] = SYX_END;
      burst.term = cmd.is_last;
      burst.count = cmd.is_last ? HEADER_LEN + TRAILER_LEN : HEADER_LEN;
      running_xor_next = cmd.is_last ? 8'h00 : hdr_xor;
      in_message_next = !cmd.is_last;
    end else if (in_message) begin
      burst.bytes[0] = cmd.data_byte;
      burst.bytes[1] = body_xor & CHECKSUM_MASK;
      burst.bytes[2] = SYX_END;
      burst.term = cmd.is_last;
      burst.count = cmd.is_last ? BURST_CNT_W'(1) + TRAILER_LEN : BURST_CNT_W'(1);
      running_xor_next = cmd.is_last ? 8'h00 : body_xor;
      in_message_next = !cmd.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manufacturer_id <= MFR_ID_W'(372);
      model_id <= MODEL_ID_W'(16);
      running_xor <= '0;
      in_message <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          CFG_MANUFACTURER_ID: manufacturer_id <= cfg.data[MFR_ID_W-1:0];
          CFG_MODEL_ID:        model_id <= cfg.data[MODEL_ID_W-1:0];
          default:             ;
        endcase
      end
      if (take) begin
        running_xor <= running_xor_next;
        in_message <= in_message_next;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/sxf_burst_buf.sv */
// Burst register and word sequencer: holds one burst and sends it a word per cycle unless msg_stall.
// Uses sxf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sxf_burst_buf
  import sxf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire burst_t burst,
  input  wire logic   load,
  output logic        busy,
  output logic        msg_valid,
  input  wire logic   msg_stall,
  output msg_word_t   msg_word
);

  logic                   held;
  burst_t                 buf_q;
  logic [BURST_IDX_W-1:0] idx;
  logic                   tail;
  logic                   vacate;

  assign tail = ({1'b0, idx} == buf_q.count - BURST_CNT_W'(1));
  assign vacate = held && !msg_stall && tail;
  assign busy = held && !vacate;

  assign msg_valid = held;
  assign msg_word.out_byte = buf_q.bytes[idx];
  assign msg_word.end_of_message = buf_q.term && tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx <= '0;
    end else if (load) begin
      held <= 1'b1;
      idx <= '0;
    end else if (vacate) begin
      held <= 1'b0;
      idx <= '0;
    end else if (held && !msg_stall) begin
      idx <= idx + BURST_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_q <= burst;
    end
  end

endmodule
`default_nettype wire

/* sv/sysex_command_framer.sv */
// Frames MIDI system-exclusive command messages. A command word marked first
// opens a message and produces six words (0xF0, three manufacturer id bytes,
// model id, function id); each later parameter word passes through as one
// word; the word marked last adds the 7-bit XOR checksum and 0xF7, the latter
// flagged end_of_message. Parameter words flow at one per cycle while msg_stall is low;
// a first or last word stalls the command side while the single output port of the
// burst register drains its burst. Non-first words outside a message are taken and
// dropped. Uses sxf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sysex_command_framer
  import sxf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire cmd_word_t             cmd_word,
  output logic                       msg_valid,
  input  wire logic                  msg_stall,
  output msg_word_t                  msg_word,
  input  wire logic                  cfg_we,
  input  wire cfg_index_t            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_write_t cfg;
  burst_t     burst;
  logic       busy;
  logic       take;
  logic       load;

  assign cfg.we = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data = cfg_data;

  assign cmd_stall = busy;
  assign take = cmd_valid && !busy;
  assign load = take && (burst.count != '0);

  sxf_framer u_framer (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cmd   (cmd_word),
    .take  (take),
    .burst (burst)
  );

  sxf_burst_buf u_burst_buf (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .load      (load),
    .busy      (busy),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_word  (msg_word)
  );

endmodule
`default_nettype wire

/* sv/sxf_checker.sv */
// Port-level checks for sysex_command_framer, bound to the top level.
// Uses sxf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sxf_checker
  import sxf_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cmd_valid,
  input wire logic       cmd_stall,
  input wire cmd_word_t  cmd_word,
  input wire logic       msg_valid,
  input wire logic       msg_stall,
  input wire msg_word_t  msg_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_stall |=> msg_valid && $stable(msg_word))
    else $error("stalled message word changed");

  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_word.end_of_message |-> msg_word.out_byte == SYX_END)
    else $error("end marker on a byte other than 0xF7");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !msg_valid)
    else $error("message word valid after reset");

  a_open: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd_word.is_first && !msg_valid
    |=> msg_valid && msg_word.out_byte == SYX_START && !msg_word.end_of_message)
    else $error("new message did not start with 0xF0");

endmodule

bind sysex_command_framer sxf_checker u_sxf_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd_word  (cmd_word),
  .msg_valid (msg_valid),
  .msg_stall (msg_stall),
  .msg_word  (msg_word)
);
`default_nettype wire

/* dv/tb_sysex_command_framer.sv */
// Self-checking testbench for sysex_command_framer: a directed table, then random
// messages over several id settings, checked word by word against a local frame predictor
// or the expected words of typed table rows. Depends on sxf_pkg and the sysex_command_framer RTL.
`timescale 1ns / 1ps
module tb_sysex_command_framer;
  import sxf_pkg::*;

  localparam int DIR_N = 21;
  localparam int PHASE_ITEMS = 18;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    cmd_word_t           cmd;
    logic                typed;
    logic [3:0]          n;
    msg_word_t [7:0]     exp;
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_word_t             cmd_word = '0;
  logic                  msg_valid;
  logic                  msg_stall = 1'b0;
  msg_word_t             msg_word;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_MANUFACTURER_ID;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cmd_row_t              pend_row = '0;
  cmd_row_t              dir_rows [DIR_N];
  cmd_row_t              stim_q [$];
  msg_word_t             framed_q [$];

  logic [MFR_ID_W-1:0]   mfr_mirror = MFR_ID_W'(372);
  logic [MODEL_ID_W-1:0] model_mirror = MODEL_ID_W'(16);
  logic [7:0]            xor_acc = '0;
  logic                  msg_open = 1'b0;

  int                    fail_cnt = 0;
  int                    idle_cycles = 0;
  int                    stall_tick = 0;
  int                    burst_left = 0;

  sysex_command_framer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_word  (msg_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic msg_word_t mw(input logic [7:0] b, input logic eom);
    msg_word_t w;
    w.out_byte = b;
    w.end_of_message = eom;
    return w;
  endfunction

  function automatic cmd_row_t cmd_row(input logic [7:0] b, input logic first,
                                       input logic last);
    cmd_row_t r;
    r = '0;
    r.cmd.data_byte = b;
    r.cmd.is_first = first;
    r.cmd.is_last = last;
    return r;
  endfunction

  // Advances the framer state for one accepted command word; queues its words if emit.
  function automatic void frame_command(input cmd_word_t w, input bit emit);
    msg_word_t  words [$];
    logic [7:0] m0, m1, m2, md;
    m0 = {3'b000, mfr_mirror[20:16]};
    m1 = {1'b0, mfr_mirror[14:8]};
    m2 = {1'b0, mfr_mirror[6:0]};
    md = {1'b0, model_mirror};
    if (w.is_first) begin
      words.push_back(mw(SYX_START, 1'b0));
      words.push_back(mw(m0, 1'b0));
      words.push_back(mw(m1, 1'b0));
      words.push_back(mw(m2, 1'b0));
      words.push_back(mw(md, 1'b0));
      words.push_back(mw(w.data_byte, 1'b0));
      xor_acc = SYX_START ^ m0 ^ m1 ^ m2 ^ md ^ w.data_byte;
      msg_open = 1'b1;
    end else if (msg_open) begin
      words.push_back(mw(w.data_byte, 1'b0));
      xor_acc = xor_acc ^ w.data_byte;
    end
    if (msg_open && w.is_last) begin
      words.push_back(mw(xor_acc & CHECKSUM_MASK, 1'b0));
      words.push_back(mw(SYX_END, 1'b1));
      xor_acc = '0;
      msg_open = 1'b0;
    end
    if (emit)
      foreach (words[i]) framed_q.push_back(words[i]);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_command(input cmd_row_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_word <= r.cmd;
    pend_row <= r;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_and_write(input logic [MFR_ID_W-1:0] mfr,
                                  input logic [MODEL_ID_W-1:0] model);
    cmd_valid <= 1'b0;
    while (framed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MANUFACTURER_ID;
    cfg_data <= mfr;
    @(negedge clk);
    cfg_index <= CFG_MODEL_ID;
    cfg_data <= CFG_DATA_W'(model);
    @(negedge clk);
    cfg_we <= 1'b0;
    mfr_mirror = mfr;
    model_mirror = model;
  endtask

  // Mostly complete messages; some single-word, abandoned and stray words.
  task automatic queue_traffic(input int target);
    int produced, k, kind;
    produced = 0;
    while (produced < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        stim_q.push_back(cmd_row(8'($urandom), 1'b1, 1'b0));
        k = $urandom_range(0, 6);
        repeat (k) stim_q.push_back(cmd_row(8'($urandom), 1'b0, 1'b0));
        stim_q.push_back(cmd_row(8'($urandom), 1'b0, 1'b1));
        produced += k + 2;
      end else if (kind == 7) begin
        stim_q.push_back(cmd_row(8'($urandom), 1'b1, 1'b1));
        produced++;
      end else if (kind == 8) begin
        stim_q.push_back(cmd_row(8'($urandom), 1'b1, 1'b0));
        k = $urandom_range(0, 3);
        repeat (k) stim_q.push_back(cmd_row(8'($urandom), 1'b0, 1'b0));
        produced += k + 1;
      end else begin
        stim_q.push_back(cmd_row(8'($urandom), 1'b0, 1'($urandom)));
        produced++;
      end
    end
  endtask

  always @(negedge clk) begin
    stall_tick++;
    case ((stall_tick / 64) % 4)
      0: msg_stall <= 1'b0;
      1: msg_stall <= (stall_tick % 3) == 0;
      2: msg_stall <= 1'($urandom_range(0, 1));
      default: msg_stall <= (stall_tick % 16) < 9;
    endcase
  end

  always @(posedge clk) begin : monitor
    msg_word_t want;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        frame_command(pend_row.cmd, !pend_row.typed);
        if (pend_row.typed)
          for (int i = 0; i < int'(pend_row.n); i++) framed_q.push_back(pend_row.exp[i]);
      end
      if (msg_valid && !msg_stall) begin
        if (framed_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected word: out_byte=%h end_of_message=%b",
                     msg_word.out_byte, msg_word.end_of_message);
          fail_cnt++;
        end else begin
          want = framed_q.pop_front();
          if (msg_word.out_byte !== want.out_byte ||
              msg_word.end_of_message !== want.end_of_message) begin
            if (fail_cnt < 10)
              $display("word mismatch: out_byte exp %h got %h, end_of_message exp %b got %b",
                       want.out_byte, msg_word.out_byte,
                       want.end_of_message, msg_word.end_of_message);
            fail_cnt++;
          end
        end
      end
      if ((cmd_valid && !cmd_stall) || (msg_valid && !msg_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_sysex_command_framer: errors");
        $finish;
      end
    end
  end

  initial begin
    dir_rows[0] = cmd_row(8'h55, 1'b0, 1'b0);
    dir_rows[0].typed = 1'b1;
    dir_rows[1] = cmd_row(8'hFF, 1'b0, 1'b1);
    dir_rows[1].typed = 1'b1;
    dir_rows[2] = cmd_row(8'h00, 1'b1, 1'b1);
    dir_rows[2].typed = 1'b1;
    dir_rows[2].n = 4'd8;
    dir_rows[2].exp = {mw(SYX_END, 1'b1), mw(8'h15, 1'b0), mw(8'h00, 1'b0), mw(8'h10, 1'b0),
                       mw(8'h74, 1'b0), mw(8'h01, 1'b0), mw(8'h00, 1'b0),
                       mw(SYX_START, 1'b0)};
    dir_rows[3] = cmd_row(8'hFF, 1'b1, 1'b1);
    dir_rows[3].typed = 1'b1;
    dir_rows[3].n = 4'd8;
    dir_rows[3].exp = {mw(SYX_END, 1'b1), mw(8'h6A, 1'b0), mw(8'hFF, 1'b0), mw(8'h10, 1'b0),
                       mw(8'h74, 1'b0), mw(8'h01, 1'b0), mw(8'h00, 1'b0),
                       mw(SYX_START, 1'b0)};
    dir_rows[4] = cmd_row(8'h7F, 1'b1, 1'b0);
    dir_rows[5] = cmd_row(8'h00, 1'b0, 1'b0);
    dir_rows[6] = cmd_row(8'h80, 1'b0, 1'b0);
    dir_rows[7] = cmd_row(8'hFF, 1'b0, 1'b0);
    dir_rows[8] = cmd_row(8'h01, 1'b0, 1'b1);
    // restart while open: old message dropped without trailer
    dir_rows[9] = cmd_row(8'h12, 1'b1, 1'b0);
    dir_rows[10] = cmd_row(8'h34, 1'b0, 1'b0);
    dir_rows[11] = cmd_row(8'h56, 1'b1, 1'b0);
    dir_rows[12] = cmd_row(8'hAA, 1'b0, 1'b0);
    dir_rows[13] = cmd_row(8'h55, 1'b0, 1'b1);
    dir_rows[14] = cmd_row(8'h80, 1'b1, 1'b1);
    dir_rows[15] = cmd_row(8'h33, 1'b0, 1'b0);
    dir_rows[15].typed = 1'b1;
    dir_rows[16] = cmd_row(8'h01, 1'b1, 1'b0);
    dir_rows[17] = cmd_row(8'h00, 1'b0, 1'b1);
    dir_rows[18] = cmd_row(8'h7E, 1'b0, 1'b1);
    dir_rows[18].typed = 1'b1;
    dir_rows[19] = cmd_row(8'hC3, 1'b1, 1'b0);
    dir_rows[20] = cmd_row(8'h3C, 1'b0, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) send_command(dir_rows[i]);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: settle_and_write('0, '0);
        1: settle_and_write('1, '1);
        2, 3: settle_and_write(MFR_ID_W'($urandom_range(0, 21'h1FFFFF)),
                               MODEL_ID_W'($urandom_range(0, 127)));
        default: settle_and_write(MFR_ID_W'(372), MODEL_ID_W'(16));
      endcase
      queue_traffic(PHASE_ITEMS);
      while (stim_q.size() != 0) send_command(stim_q.pop_front());
    end

    cmd_valid <= 1'b0;
    while (framed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0)
      $display("tb_sysex_command_framer: clean");
    else
      $display("tb_sysex_command_framer: errors");
    $finish;
  end

endmodule
